FILE: rtl/sawlc_pkg.sv
package sawlc_pkg;

	// Fixed field widths
	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 16;
	localparam int VW_W     = 13;
	localparam int CNT_W    = 32;
	localparam int ACT_W    = 3;
	localparam int CFG_IX_W = 2;
	localparam int LIM_W    = ADDR_W + 1;

	// Default geometry
	localparam int WORDS_PER_BLOCK_DEF = 4;
	localparam int WAYS_DEF            = 2;
	localparam int SETS_DEF            = 16;
	localparam int BACKING_WORDS_DEF   = 4096;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_READ    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FLUSH   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_INVAL   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLRSTAT = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DREAD   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_DWRITE  = 3'd6;
	localparam logic [ACT_W-1:0] ACT_UNUSED  = 3'd7;

	// Configuration register indexes
	localparam logic [CFG_IX_W-1:0] CFG_VALID_WORDS = 2'd0;
	localparam logic [CFG_IX_W-1:0] CFG_CHAR_OUT    = 2'd1;
	localparam logic [CFG_IX_W-1:0] CFG_INT_OUT     = 2'd2;

	localparam logic [VW_W-1:0]   VALID_WORDS_RST = 13'd4096;
	localparam logic [ADDR_W-1:0] CHAR_OUT_RST    = 16'hFFFF;
	localparam logic [ADDR_W-1:0] INT_OUT_RST     = 16'hFFFE;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_value;
	} in_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              hit;
		logic              wrote_back;
		logic              status;
		logic [CNT_W-1:0]  read_total;
		logic [CNT_W-1:0]  write_total;
		logic [CNT_W-1:0]  hit_total;
		logic [CNT_W-1:0]  miss_total;
	} out_item_t;

	typedef struct packed {
		logic [VW_W-1:0]   valid_words;
		logic [ADDR_W-1:0] char_out_addr;
		logic [ADDR_W-1:0] int_out_addr;
	} cfg_regs_t;

	// Classified command handed from front to back
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_value;
		logic              in_range;
		logic              port_addr;
	} cmd_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_HIT_RD,
		ST_WB_RD,
		ST_WB_WR,
		ST_FILL_RD,
		ST_FILL_WR,
		ST_FILL_END,
		ST_FL_SCAN,
		ST_DR_WAIT,
		ST_DONE
	} back_state_t;

	// Usable word count: min(valid_words, backing size)
	function automatic logic [LIM_W-1:0] word_limit(logic [VW_W-1:0] vw, int unsigned bw);
		logic [LIM_W-1:0] bwl;
		bwl = LIM_W'(bw);
		word_limit = ({4'd0, vw} < bwl) ? {4'd0, vw} : bwl;
	endfunction

endpackage

FILE: rtl/set_assoc_writeback_lru_cache.sv
// Set-associative write-back, write-allocate cache with per-set LRU ranks and
// its backing word store inside. Items enter through a two-deep command queue
// and results leave through a one-entry result register, each side a queue
// interface. After reset the backing store is zeroed one word a cycle, and
// full stays high until the whole store is clear; configuration
// writes are taken at any time. Each item runs in the single back-end
// sequencer: a write hit updates the line in the execute state and a
// read hit reads the line word back, a miss fills the block one word at a
// time after writing back a dirty victim word by word, a flush scans every
// line and writes back each dirty one, and a direct read waits on the
// backing store. After handing its result to the result register the back
// end goes idle and takes the next queued item from there. The line data
// and backing store are single-port RAMs.
module set_assoc_writeback_lru_cache #(
	parameter int WORDS_PER_BLOCK = sawlc_pkg::WORDS_PER_BLOCK_DEF,
	parameter int WAYS            = sawlc_pkg::WAYS_DEF,
	parameter int SETS            = sawlc_pkg::SETS_DEF,
	parameter int BACKING_WORDS   = sawlc_pkg::BACKING_WORDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  sawlc_pkg::in_item_t                 item,
	output logic                                empty,
	input  logic                                pop,
	output sawlc_pkg::out_item_t                result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sawlc_pkg::CFG_IX_W-1:0]      cfg_index,
	input  logic [sawlc_pkg::ADDR_W-1:0]        cfg_data
);
	import sawlc_pkg::*;

	cfg_regs_t  cfg_q;
	back_stat_t bstat;
	cmd_t       cmd;
	logic       cmd_valid, cmd_take;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valid_words   <= VALID_WORDS_RST;
			cfg_q.char_out_addr <= CHAR_OUT_RST;
			cfg_q.int_out_addr  <= INT_OUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_VALID_WORDS: cfg_q.valid_words   <= cfg_data[VW_W-1:0];
				CFG_CHAR_OUT:    cfg_q.char_out_addr <= cfg_data;
				CFG_INT_OUT:     cfg_q.int_out_addr  <= cfg_data;
				default: ;
			endcase
		end
	end

	sawlc_front #(.BACKING_WORDS(BACKING_WORDS)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.cfg(cfg_q), .bstat(bstat), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take)
	);

	sawlc_back #(
		.WORDS_PER_BLOCK(WORDS_PER_BLOCK), .WAYS(WAYS), .SETS(SETS),
		.BACKING_WORDS(BACKING_WORDS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .cmd_valid(cmd_valid), .cmd(cmd),
		.cmd_take(cmd_take), .bstat(bstat), .empty(empty), .pop(pop), .result(result)
	);

endmodule

FILE: rtl/sawlc_ram.sv
module sawlc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: rtl/sawlc_front.sv
module sawlc_front #(
	parameter int BACKING_WORDS = sawlc_pkg::BACKING_WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  sawlc_pkg::in_item_t    item,
	input  sawlc_pkg::cfg_regs_t   cfg,
	input  sawlc_pkg::back_stat_t  bstat,
	output logic                   cmd_valid,
	output sawlc_pkg::cmd_t        cmd,
	input  logic                   cmd_take
);
	import sawlc_pkg::*;

	localparam int QD = 2;

	cmd_t             buf_q [QD];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic [LIM_W-1:0] lim;
	cmd_t             cls;
	logic             do_push, do_pop;

	// Classify the incoming item
	always_comb begin
		lim             = word_limit(cfg.valid_words, BACKING_WORDS);
		cls.action      = item.action;
		cls.address     = item.address;
		cls.write_value = item.write_value;
		cls.in_range    = {1'b0, item.address} < lim;
		cls.port_addr   = (item.address == cfg.char_out_addr) ||
		                  (item.address == cfg.int_out_addr);
	end

	assign full      = (cnt_q == 2'(QD)) || bstat.clearing;
	assign do_push   = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign do_pop    = cmd_take && cmd_valid;
	assign cmd       = buf_q[rd_ptr_q];

	// Payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

FILE: rtl/sawlc_back.sv
module sawlc_back #(
	parameter int WORDS_PER_BLOCK = sawlc_pkg::WORDS_PER_BLOCK_DEF,
	parameter int WAYS            = sawlc_pkg::WAYS_DEF,
	parameter int SETS            = sawlc_pkg::SETS_DEF,
	parameter int BACKING_WORDS   = sawlc_pkg::BACKING_WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sawlc_pkg::cfg_regs_t   cfg,
	input  logic                   cmd_valid,
	input  sawlc_pkg::cmd_t        cmd,
	output logic                   cmd_take,
	output sawlc_pkg::back_stat_t  bstat,
	output logic                   empty,
	input  logic                   pop,
	output sawlc_pkg::out_item_t   result
);
	import sawlc_pkg::*;

	localparam int OFF_W   = WORDS_PER_BLOCK > 1 ? $clog2(WORDS_PER_BLOCK) : 1;
	localparam int SET_W   = SETS > 1 ? $clog2(SETS) : 1;
	localparam int WAY_W   = WAYS > 1 ? $clog2(WAYS) : 1;
	localparam int AGE_W   = WAY_W;
	localparam int SPAN    = WORDS_PER_BLOCK * SETS;
	localparam int TAGS    = (65536 + SPAN - 1) / SPAN;
	localparam int TAG_W   = TAGS > 1 ? $clog2(TAGS) : 1;
	localparam int LDEPTH  = SETS * WAYS * WORDS_PER_BLOCK;
	localparam int LAW     = LDEPTH > 1 ? $clog2(LDEPTH) : 1;
	localparam int BAW     = BACKING_WORDS > 1 ? $clog2(BACKING_WORDS) : 1;

	back_state_t state_q, state_d;

	// Line state per way, indexed by set
	logic [SETS-1:0]  valid_q [WAYS];
	logic [SETS-1:0]  dirty_q [WAYS];
	logic [TAG_W-1:0] tag_q   [WAYS][SETS];
	logic [AGE_W-1:0] age_q   [WAYS][SETS];

	cmd_t             cur_q;
	logic [SET_W-1:0] set_q;
	logic [OFF_W-1:0] off_q;
	logic [TAG_W-1:0] atag_q;
	logic [WAY_W-1:0] way_q;
	logic [OFF_W-1:0] i_q;
	logic             flush_q;
	logic [BAW-1:0]   clr_q;
	logic [DATA_W-1:0] rd_q;
	logic             hit_q, wb_q, status_q;
	logic [CNT_W-1:0] reads_q, writes_q, hits_q, misses_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic [LIM_W-1:0] lim;
	logic             found;
	logic [WAY_W-1:0] hit_way, vic_way;
	logic             any_inv;
	logic [LIM_W-1:0] wb_addr, fill_addr;
	logic             wb_ok, fill_ok, last_word, last_line, out_free;
	logic [DATA_W-1:0] fill_word;

	// Memory ports
	logic              l_we, b_we;
	logic [LAW-1:0]    l_addr;
	logic [BAW-1:0]    b_addr;
	logic [DATA_W-1:0] l_wdata, b_wdata, l_rdata, b_rdata;

	sawlc_ram #(.WIDTH(DATA_W), .DEPTH(LDEPTH)) u_line_ram (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
	);

	sawlc_ram #(.WIDTH(DATA_W), .DEPTH(BACKING_WORDS)) u_back_ram (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
	);

	// Tag match and victim choice over the ways of the current set
	always_comb begin
		found   = 1'b0;
		hit_way = '0;
		any_inv = 1'b0;
		vic_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && valid_q[w][set_q] && tag_q[w][set_q] == atag_q) begin
				found   = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!any_inv && !valid_q[w][set_q]) begin
				any_inv = 1'b1;
				vic_way = WAY_W'(w);
			end
		end
		if (!any_inv) begin
			for (int w = 1; w < WAYS; w++) begin
				if (age_q[w][set_q] > age_q[vic_way][set_q]) vic_way = WAY_W'(w);
			end
		end
	end

	// Address arithmetic for the block moves
	always_comb begin
		lim       = word_limit(cfg.valid_words, BACKING_WORDS);
		wb_addr   = LIM_W'((int'(tag_q[way_q][set_q]) * SETS + int'(set_q)) * WORDS_PER_BLOCK
		            + int'(i_q));
		fill_addr = LIM_W'((int'(atag_q) * SETS + int'(set_q)) * WORDS_PER_BLOCK + int'(i_q));
		wb_ok     = wb_addr < lim;
		fill_ok   = fill_addr < lim;
		last_word = i_q == OFF_W'(WORDS_PER_BLOCK - 1);
		last_line = (set_q == SET_W'(SETS - 1)) && (way_q == WAY_W'(WAYS - 1));
		out_free  = !out_valid_q || pop;
		fill_word = fill_ok ? b_rdata : '0;
		if (cur_q.action == ACT_WRITE && i_q == off_q) fill_word = cur_q.write_value;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    if (clr_q == BAW'(BACKING_WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE:     if (cmd_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				priority if (cur_q.action == ACT_READ || cur_q.action == ACT_WRITE) begin
					if (!cur_q.in_range) state_d = ST_DONE;
					else if (found) state_d = (cur_q.action == ACT_READ) ? ST_HIT_RD : ST_DONE;
					else if (valid_q[vic_way][set_q] && dirty_q[vic_way][set_q])
						state_d = ST_WB_RD;
					else state_d = ST_FILL_RD;
				end else if (cur_q.action == ACT_FLUSH) begin
					state_d = ST_FL_SCAN;
				end else if (cur_q.action == ACT_DREAD && cur_q.in_range) begin
					state_d = ST_DR_WAIT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_HIT_RD:   state_d = ST_DONE;
			ST_WB_RD:    state_d = ST_WB_WR;
			ST_WB_WR: begin
				if (!last_word) state_d = ST_WB_RD;
				else if (!flush_q) state_d = ST_FILL_RD;
				else state_d = last_line ? ST_DONE : ST_FL_SCAN;
			end
			ST_FILL_RD:  state_d = ST_FILL_WR;
			ST_FILL_WR:  state_d = last_word ? ST_FILL_END : ST_FILL_RD;
			ST_FILL_END: state_d = ST_DONE;
			ST_FL_SCAN: begin
				if (valid_q[way_q][set_q] && dirty_q[way_q][set_q]) state_d = ST_WB_RD;
				else if (last_line) state_d = ST_DONE;
			end
			ST_DR_WAIT:  state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory controls and handshake outputs
	always_comb begin
		cmd_take       = (state_q == ST_IDLE);
		bstat.clearing = (state_q == ST_CLEAR);
		l_we    = 1'b0;
		b_we    = 1'b0;
		l_wdata = cur_q.write_value;
		b_wdata = '0;
		b_addr  = '0;
		l_addr  = LAW'((int'(set_q) * WAYS + int'(way_q)) * WORDS_PER_BLOCK + int'(i_q));
		unique case (state_q)
			ST_CLEAR: begin
				b_we   = 1'b1;
				b_addr = clr_q;
			end
			ST_EXEC: begin
				l_addr = LAW'((int'(set_q) * WAYS + int'(hit_way)) * WORDS_PER_BLOCK
				         + int'(off_q));
				l_we   = (cur_q.action == ACT_WRITE) && cur_q.in_range && found;
				b_addr = cur_q.address[BAW-1:0];
				b_wdata = cur_q.write_value;
				b_we   = (cur_q.action == ACT_DWRITE) && cur_q.in_range && !cur_q.port_addr;
			end
			ST_WB_WR: begin
				b_addr  = wb_addr[BAW-1:0];
				b_wdata = l_rdata;
				b_we    = wb_ok;
			end
			ST_FILL_RD: b_addr = fill_addr[BAW-1:0];
			ST_FILL_WR: begin
				l_we    = 1'b1;
				l_wdata = fill_word;
			end
			default: ;
		endcase
	end

	// Non-reset working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cur_q  <= cmd;
			off_q  <= OFF_W'(cmd.address % WORDS_PER_BLOCK);
			set_q  <= SET_W'((cmd.address / WORDS_PER_BLOCK) % SETS);
			atag_q <= TAG_W'(cmd.address / SPAN);
		end
		unique case (state_q)
			ST_EXEC: begin
				i_q <= '0;
				if (cur_q.action == ACT_FLUSH) begin
					set_q <= '0;
					way_q <= '0;
				end else begin
					way_q <= found ? hit_way : vic_way;
				end
			end
			ST_HIT_RD, ST_DR_WAIT: rd_q <= (state_q == ST_HIT_RD) ? l_rdata : b_rdata;
			ST_WB_WR: begin
				i_q <= last_word ? '0 : i_q + OFF_W'(1);
				if (last_word && flush_q && !last_line) begin
					if (way_q == WAY_W'(WAYS - 1)) begin
						way_q <= '0;
						set_q <= set_q + SET_W'(1);
					end else begin
						way_q <= way_q + WAY_W'(1);
					end
				end
			end
			ST_FILL_WR: begin
				i_q <= last_word ? '0 : i_q + OFF_W'(1);
				if (i_q == off_q && cur_q.action == ACT_READ) rd_q <= fill_word;
			end
			ST_FL_SCAN: begin
				i_q <= '0;
				if (!(valid_q[way_q][set_q] && dirty_q[way_q][set_q]) && !last_line) begin
					if (way_q == WAY_W'(WAYS - 1)) begin
						way_q <= '0;
						set_q <= set_q + SET_W'(1);
					end else begin
						way_q <= way_q + WAY_W'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// Control state, line state, counters and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			flush_q     <= 1'b0;
			hit_q       <= 1'b0;
			wb_q        <= 1'b0;
			status_q    <= 1'b0;
			reads_q     <= '0;
			writes_q    <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			out_valid_q <= 1'b0;
			for (int w = 0; w < WAYS; w++) begin
				valid_q[w] <= '0;
				dirty_q[w] <= '0;
				for (int s = 0; s < SETS; s++) begin
					tag_q[w][s] <= '0;
					age_q[w][s] <= '0;
				end
			end
		end else begin
			state_q <= state_d;
			if (pop && out_valid_q) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + BAW'(1);
				ST_IDLE: begin
					hit_q    <= 1'b0;
					wb_q     <= 1'b0;
					status_q <= 1'b0;
					flush_q  <= 1'b0;
				end
				ST_EXEC: begin
					priority if (cur_q.action == ACT_READ || cur_q.action == ACT_WRITE) begin
						if (!cur_q.in_range) begin
							status_q <= 1'b1;
						end else begin
							if (cur_q.action == ACT_WRITE) writes_q <= writes_q + 1'b1;
							else reads_q <= reads_q + 1'b1;
							if (found) begin
								hits_q <= hits_q + 1'b1;
								hit_q  <= 1'b1;
								// Move the hit way to rank zero
								for (int w = 0; w < WAYS; w++) begin
									if (WAY_W'(w) != hit_way && valid_q[w][set_q] &&
									    age_q[w][set_q] < age_q[hit_way][set_q])
										age_q[w][set_q] <= age_q[w][set_q] + AGE_W'(1);
								end
								age_q[hit_way][set_q] <= '0;
								if (cur_q.action == ACT_WRITE) dirty_q[hit_way][set_q] <= 1'b1;
							end else begin
								misses_q <= misses_q + 1'b1;
								if (valid_q[vic_way][set_q] && dirty_q[vic_way][set_q])
									wb_q <= 1'b1;
							end
						end
					end else if (cur_q.action == ACT_FLUSH) begin
						flush_q <= 1'b1;
					end else if (cur_q.action == ACT_INVAL) begin
						reads_q  <= '0;
						writes_q <= '0;
						hits_q   <= '0;
						misses_q <= '0;
						for (int w = 0; w < WAYS; w++) begin
							valid_q[w] <= '0;
							dirty_q[w] <= '0;
							for (int s = 0; s < SETS; s++) begin
								tag_q[w][s] <= '0;
								age_q[w][s] <= '0;
							end
						end
					end else if (cur_q.action == ACT_CLRSTAT) begin
						reads_q  <= '0;
						writes_q <= '0;
						hits_q   <= '0;
						misses_q <= '0;
					end else if (cur_q.action == ACT_DREAD || cur_q.action == ACT_DWRITE) begin
						status_q <= !cur_q.in_range &&
						            !(cur_q.action == ACT_DWRITE && cur_q.port_addr);
					end else begin
						status_q <= 1'b0;
					end
				end
				ST_WB_WR: if (last_word && flush_q) dirty_q[way_q][set_q] <= 1'b0;
				ST_FL_SCAN: if (valid_q[way_q][set_q] && dirty_q[way_q][set_q]) wb_q <= 1'b1;
				ST_FILL_END: begin
					// Install the new block and update ranks
					for (int w = 0; w < WAYS; w++) begin
						if (WAY_W'(w) != way_q && valid_q[w][set_q] &&
						    (!valid_q[way_q][set_q] || age_q[w][set_q] < age_q[way_q][set_q]))
							age_q[w][set_q] <= age_q[w][set_q] + AGE_W'(1);
					end
					age_q[way_q][set_q]   <= '0;
					valid_q[way_q][set_q] <= 1'b1;
					tag_q[way_q][set_q]   <= atag_q;
					dirty_q[way_q][set_q] <= cur_q.action == ACT_WRITE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.read_data   <= (!status_q && (cur_q.action == ACT_READ ||
			                     cur_q.action == ACT_DREAD)) ? rd_q : '0;
			out_q.hit         <= hit_q;
			out_q.wrote_back  <= wb_q;
			out_q.status      <= status_q;
			out_q.read_total  <= reads_q;
			out_q.write_total <= writes_q;
			out_q.hit_total   <= hits_q;
			out_q.miss_total  <= misses_q;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

FILE: verif/set_assoc_writeback_lru_cache_test.sv
module set_assoc_writeback_lru_cache_test;
	import sawlc_pkg::*;

	localparam int WPB      = 4;
	localparam int NWAYS    = 2;
	localparam int NSETS    = 16;
	localparam int BACKING  = 4096;
	localparam int NLINES   = NSETS * NWAYS;
	localparam int N_RANDOM = 400;
	localparam int CYCLE_LIMIT = 900000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    item;
	logic        empty;
	logic        pop;
	out_item_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]   cfg_data;

	set_assoc_writeback_lru_cache u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Cache shadow state
	logic [VW_W-1:0]   sh_valid_words;
	logic [ADDR_W-1:0] sh_char_out;
	logic [ADDR_W-1:0] sh_int_out;
	bit                sh_valid [NLINES];
	bit                sh_dirty [NLINES];
	logic [9:0]        sh_tag   [NLINES];
	int unsigned       sh_age   [NLINES];
	logic [DATA_W-1:0] sh_line  [NLINES*WPB];
	logic [DATA_W-1:0] sh_mem   [BACKING];
	logic [CNT_W-1:0]  n_reads, n_writes, n_hits, n_misses;

	out_item_t   pending_results [$];
	int          mismatches;
	bit          failed;
	bit          long_hold;
	bit          no_idle;
	int unsigned cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Cycle counter watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("set_assoc_writeback_lru_cache_test: FAIL");
			$finish;
		end
	end

	function automatic int unsigned usable_words();
		return (sh_valid_words < BACKING) ? sh_valid_words : BACKING;
	endfunction

	function automatic void clear_counters();
		n_reads = 0; n_writes = 0; n_hits = 0; n_misses = 0;
	endfunction

	function automatic void clear_cache_lines();
		for (int l = 0; l < NLINES; l++) begin
			sh_valid[l] = 0; sh_dirty[l] = 0; sh_tag[l] = 0; sh_age[l] = 0;
		end
		for (int i = 0; i < NLINES*WPB; i++) sh_line[i] = 0;
	endfunction

	function automatic void write_back_line(int line, int set);
		int unsigned base;
		base = (sh_tag[line] * NSETS + set) * WPB;
		for (int i = 0; i < WPB; i++)
			if (base + i < usable_words()) sh_mem[base + i] = sh_line[line*WPB + i];
	endfunction

	// LRU rank update on use of one way
	function automatic void promote_way(int set, int way, bit was_valid);
		int unsigned mine;
		int l;
		mine = sh_age[set*NWAYS + way];
		for (int w = 0; w < NWAYS; w++) begin
			l = set*NWAYS + w;
			if (w != way && sh_valid[l] && (!was_valid || sh_age[l] < mine))
				sh_age[l]++;
		end
		sh_age[set*NWAYS + way] = 0;
	endfunction

	function automatic void cache_access(input logic [ADDR_W-1:0] addr, input bit is_wr,
			input logic [DATA_W-1:0] value, inout out_item_t r);
		int off, set, way, line;
		logic [9:0] tag;
		bit found, was_valid;
		int unsigned base;
		off = addr % WPB;
		set = (addr / WPB) % NSETS;
		tag = 10'(addr / (WPB * NSETS));
		found = 0;
		way = 0;
		if (is_wr) n_writes++; else n_reads++;
		for (int w = 0; w < NWAYS; w++)
			if (!found && sh_valid[set*NWAYS+w] && sh_tag[set*NWAYS+w] == tag) begin
				found = 1; way = w;
			end
		if (found) begin
			n_hits++;
			r.hit = 1;
			line = set*NWAYS + way;
			promote_way(set, way, 1);
			if (is_wr) begin
				sh_line[line*WPB + off] = value;
				sh_dirty[line] = 1;
			end else r.read_data = sh_line[line*WPB + off];
			return;
		end
		n_misses++;
		for (int w = 0; w < NWAYS; w++)
			if (!found && !sh_valid[set*NWAYS+w]) begin
				found = 1; way = w;
			end
		if (!found) begin
			way = 0;
			for (int w = 1; w < NWAYS; w++)
				if (sh_age[set*NWAYS+w] > sh_age[set*NWAYS+way]) way = w;
		end
		line = set*NWAYS + way;
		was_valid = sh_valid[line];
		if (was_valid && sh_dirty[line]) begin
			write_back_line(line, set);
			r.wrote_back = 1;
		end
		base = addr - off;
		for (int i = 0; i < WPB; i++)
			sh_line[line*WPB + i] = (base + i < usable_words()) ? sh_mem[base + i] : '0;
		promote_way(set, way, was_valid);
		sh_valid[line] = 1;
		sh_tag[line] = tag;
		if (is_wr) begin
			sh_line[line*WPB + off] = value;
			sh_dirty[line] = 1;
		end else begin
			sh_dirty[line] = 0;
			r.read_data = sh_line[line*WPB + off];
		end
	endfunction

	// Expected result of one item, updating the shadow state
	function automatic out_item_t predict_cache_op(in_item_t it);
		out_item_t r;
		r = '0;
		case (it.action)
			ACT_READ, ACT_WRITE: begin
				if (it.address >= usable_words()) r.status = 1;
				else cache_access(it.address, it.action == ACT_WRITE, it.write_value, r);
			end
			ACT_FLUSH: begin
				for (int l = 0; l < NLINES; l++)
					if (sh_valid[l] && sh_dirty[l]) begin
						write_back_line(l, l / NWAYS);
						sh_dirty[l] = 0;
						r.wrote_back = 1;
					end
			end
			ACT_INVAL: begin
				clear_cache_lines();
				clear_counters();
			end
			ACT_CLRSTAT: clear_counters();
			ACT_DREAD: begin
				if (it.address < usable_words()) r.read_data = sh_mem[it.address];
				else r.status = 1;
			end
			ACT_DWRITE: begin
				if (it.address != sh_char_out && it.address != sh_int_out) begin
					if (it.address < usable_words()) sh_mem[it.address] = it.write_value;
					else r.status = 1;
				end
			end
			default: ;
		endcase
		r.read_total = n_reads;
		r.write_total = n_writes;
		r.hit_total = n_hits;
		r.miss_total = n_misses;
		return r;
	endfunction

	// Consumer: random pop bursts, one long hold-off, result compare
	initial begin
		int gap;
		out_item_t want;
		pop = 0;
		mismatches = 0;
		failed = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				pop <= 0;
				repeat (300) @(negedge clk);
				long_hold = 0;
			end
			if (!no_idle && $urandom_range(0, 7) == 0) begin
				pop <= 0;
				gap = $urandom_range(1, 18);
				repeat (gap) @(negedge clk);
			end
			pop <= 1;
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", result);
				end else begin
					want = pending_results.pop_front();
					if (want !== result) begin
						failed = 1;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", want, result);
					end
				end
			end
		end
	end

	task automatic write_reg(logic [CFG_IX_W-1:0] idx, logic [ADDR_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		case (idx)
			CFG_VALID_WORDS: sh_valid_words = data[VW_W-1:0];
			CFG_CHAR_OUT:    sh_char_out = data;
			CFG_INT_OUT:     sh_int_out = data;
			default: ;
		endcase
	endtask

	// One transfer into the block; expectation queued on accept
	task automatic send_item(in_item_t it, bit idle_ok);
		int gap;
		if (idle_ok && !no_idle && $urandom_range(0, 7) == 0) begin
			push <= 0;
			gap = $urandom_range(1, 18);
			repeat (gap) @(negedge clk);
		end
		push <= 1;
		item <= it;
		do @(posedge clk); while (full);
		pending_results.push_back(predict_cache_op(it));
		@(negedge clk);
	endtask

	task automatic drain_results();
		push <= 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic in_item_t mk(logic [ACT_W-1:0] a, logic [ADDR_W-1:0] ad,
			logic [DATA_W-1:0] v);
		in_item_t it;
		it.action = a; it.address = ad; it.write_value = v;
		return it;
	endfunction

	typedef struct {
		in_item_t  stim;
		bit        fixed;
		out_item_t outcome;
	} directed_row_t;

	directed_row_t directed_rows [$];

	function automatic out_item_t lit(logic [15:0] rd, bit h, bit wb, bit st,
			int unsigned r, int unsigned w, int unsigned hh, int unsigned m);
		out_item_t o;
		o.read_data = rd; o.hit = h; o.wrote_back = wb; o.status = st;
		o.read_total = r; o.write_total = w; o.hit_total = hh; o.miss_total = m;
		return o;
	endfunction

	function automatic void row(in_item_t it);
		directed_row_t d;
		d.stim = it; d.fixed = 0; d.outcome = '0;
		directed_rows.push_back(d);
	endfunction

	function automatic void row_fixed(in_item_t it, out_item_t o);
		directed_row_t d;
		d.stim = it; d.fixed = 1; d.outcome = o;
		directed_rows.push_back(d);
	endfunction

	// Random item, mostly a small hot address window so sets conflict
	function automatic in_item_t random_item();
		in_item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		it.write_value = DATA_W'($urandom());
		if ($urandom_range(0, 9) < 8)
			it.address = ADDR_W'(($urandom_range(0, 5) * 64) + $urandom_range(0, 63));
		else
			it.address = ADDR_W'($urandom());
		if (sel < 40)      it.action = ACT_READ;
		else if (sel < 75) it.action = ACT_WRITE;
		else if (sel < 79) it.action = ACT_FLUSH;
		else if (sel < 81) it.action = ACT_INVAL;
		else if (sel < 83) it.action = ACT_CLRSTAT;
		else if (sel < 90) it.action = ACT_DREAD;
		else if (sel < 99) it.action = ACT_DWRITE;
		else               it.action = ACT_UNUSED;
		return it;
	endfunction

	initial begin
		out_item_t want;
		arst_n = 0;
		push = 0;
		item = '0;
		cfg_valid = 0;
		cfg_index = CFG_VALID_WORDS;
		cfg_data = '0;
		long_hold = 0;
		no_idle = 0;
		cycles = 0;
		sh_valid_words = VALID_WORDS_RST;
		sh_char_out = CHAR_OUT_RST;
		sh_int_out = INT_OUT_RST;
		clear_cache_lines();
		for (int i = 0; i < BACKING; i++) sh_mem[i] = 0;
		clear_counters();
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed table
		row_fixed(mk(ACT_READ, 16'd0, 16'h0000), lit(0, 0, 0, 0, 1, 0, 0, 1));
		row_fixed(mk(ACT_READ, 16'd0, 16'hFFFF), lit(0, 1, 0, 0, 2, 0, 1, 1));
		row(mk(ACT_WRITE, 16'd1, 16'hFFFF));
		row(mk(ACT_WRITE, 16'd64, 16'h5A5A));
		row(mk(ACT_READ, 16'd128, 16'h0000));
		row(mk(ACT_READ, 16'd1, 16'h0000));
		row(mk(ACT_WRITE, 16'd4095, 16'hA5A5));
		row_fixed(mk(ACT_READ, 16'd4096, 16'h0), lit(0, 0, 0, 1, 4, 3, 2, 5));
		row_fixed(mk(ACT_WRITE, 16'hFFFF, 16'h1234), lit(0, 0, 0, 1, 4, 3, 2, 5));
		row(mk(ACT_FLUSH, 16'd0, 16'd0));
		row(mk(ACT_FLUSH, 16'd0, 16'd0));
		row(mk(ACT_DREAD, 16'd1, 16'd0));
		row(mk(ACT_DREAD, 16'd4095, 16'd0));
		row_fixed(mk(ACT_DREAD, 16'hFFFF, 16'd0), lit(0, 0, 0, 1, 4, 3, 2, 5));
		row_fixed(mk(ACT_DWRITE, 16'hFFFF, 16'h7777), lit(0, 0, 0, 0, 4, 3, 2, 5));
		row_fixed(mk(ACT_DWRITE, 16'hFFFE, 16'h7777), lit(0, 0, 0, 0, 4, 3, 2, 5));
		row_fixed(mk(ACT_DWRITE, 16'd4096, 16'h7777), lit(0, 0, 0, 1, 4, 3, 2, 5));
		row(mk(ACT_DWRITE, 16'd2, 16'hFFFF));
		row(mk(ACT_CLRSTAT, 16'd0, 16'd0));
		row(mk(ACT_UNUSED, 16'hFFFF, 16'hFFFF));
		row(mk(ACT_WRITE, 16'd200, 16'h8001));
		row_fixed(mk(ACT_INVAL, 16'd0, 16'd0), lit(0, 0, 0, 0, 0, 0, 0, 0));
		row(mk(ACT_READ, 16'd200, 16'd0));
		foreach (directed_rows[i]) begin
			if (directed_rows[i].fixed) begin
				want = predict_cache_op(directed_rows[i].stim);
				pending_results.push_back(directed_rows[i].outcome);
				if (want !== directed_rows[i].outcome) begin
					failed = 1;
					$display("directed row %0d: table %p, predictor %p",
						i, directed_rows[i].outcome, want);
				end
				push <= 1;
				item <= directed_rows[i].stim;
				do @(posedge clk); while (full);
				@(negedge clk);
			end else send_item(directed_rows[i].stim, 1);
		end
		drain_results();

		// Random phases across register settings, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_VALID_WORDS, 16'd300);
					write_reg(CFG_CHAR_OUT, 16'd5);
					write_reg(CFG_INT_OUT, 16'd70);
				end
				1: begin
					write_reg(CFG_VALID_WORDS, 16'd1);
					write_reg(CFG_CHAR_OUT, 16'd0);
					write_reg(CFG_INT_OUT, 16'd0);
				end
				2: write_reg(CFG_VALID_WORDS, 16'd0);
				3: begin
					write_reg(CFG_VALID_WORDS, 16'h1FFF);
					write_reg(CFG_CHAR_OUT, 16'hFFFF);
					write_reg(CFG_INT_OUT, 16'hFFFE);
				end
				default: write_reg(CFG_VALID_WORDS, 16'd4096);
			endcase
			if (ph == 1) long_hold = 1;
			if (ph == 4) no_idle = 1;
			for (int n = 0; n < (ph == 2 ? 20 : N_RANDOM / 4); n++)
				send_item(random_item(), 1);
			drain_results();
		end

		if (!failed)
			$display("set_assoc_writeback_lru_cache_test: PASS");
		else
			$display("set_assoc_writeback_lru_cache_test: FAIL");
		$finish;
	end

endmodule
